>>> hdl/qtr_pkg.sv
`default_nettype none
package qtr_pkg;

    localparam int LEN_BITS  = 12;
    localparam int CFG_LEN_W = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = ((LEN_BITS > CFG_LEN_W) ? LEN_BITS : CFG_LEN_W) + 2;

    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [CMP_W-1:0]    cmp_t;

    localparam cmp_t LEN_MAX = cmp_t'((1 << LEN_BITS) - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_LATIN1  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = 12'd4095;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NBSP    = 8'hA0;
    localparam logic [7:0] HIGH_BIT   = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       bad;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) || (c == CH_NBSP);
    endfunction

endpackage
`default_nettype wire

>>> hdl/qtr_parse.sv
`default_nettype none
module qtr_parse (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    byte_in,
    input  wire logic                          eoi,
    input  wire logic                          latin1,
    input  wire logic [qtr_pkg::CFG_LEN_W-1:0] max_len,
    input  wire logic                          advance,
    output qtr_pkg::step_t                     step
);

    logic          in_quote_reg, in_quote_next;
    logic          esc_reg, esc_next;
    logic          qm_reg, qm_next;
    qtr_pkg::len_t tl_reg, tl_next;

    qtr_pkg::cmp_t lim;
    qtr_pkg::cmp_t tl_w;
    logic [7:0]    keep_c;
    logic          sp;
    logic          wide;
    logic          fit1;
    logic          fit2;
    qtr_pkg::res_t r_end;
    qtr_pkg::res_t r_k0;
    qtr_pkg::res_t r_k1;

    always_comb
    begin
        lim = qtr_pkg::cmp_t'(max_len);
        if (lim > qtr_pkg::LEN_MAX)
        begin
            lim = qtr_pkg::LEN_MAX;
        end
        tl_w   = qtr_pkg::cmp_t'(tl_reg);
        fit1   = (tl_w + qtr_pkg::cmp_t'(1)) <= lim;
        fit2   = (tl_w + qtr_pkg::cmp_t'(2)) <= lim;
        sp     = qtr_pkg::is_space(byte_in);
        keep_c = (esc_reg && byte_in == qtr_pkg::CH_N) ? qtr_pkg::CH_NEWLINE : byte_in;
        wide   = latin1 && keep_c[7];
    end

    always_comb
    begin
        r_end = '{data: 8'h00, kind: qtr_pkg::KIND_END, bad: qm_reg, last: 1'b1};
        r_k0  = '0;
        r_k1  = '0;
        if (wide)
        begin
            r_k0.data = 8'hC0 | {6'd0, keep_c[7:6]};
            r_k1.data = qtr_pkg::HIGH_BIT | {2'd0, keep_c[5:0]};
            r_k1.last = 1'b1;
        end
        else
        begin
            r_k0.data = keep_c;
            r_k0.last = 1'b1;
        end
        r_k0.kind = qtr_pkg::KIND_DATA;
        r_k1.kind = qtr_pkg::KIND_DATA;
    end

    always_comb
    begin
        in_quote_next = in_quote_reg;
        esc_next      = esc_reg;
        qm_next       = qm_reg;
        tl_next       = tl_reg;
        step          = '0;
        if (eoi)
        begin
            step.count = 2'd1;
            step.r0    = r_end;
            step.r0.kind = qtr_pkg::KIND_EOF;
            in_quote_next = 1'b0;
            esc_next      = 1'b0;
            qm_next       = 1'b0;
            tl_next       = '0;
        end
        else if (!esc_reg && sp && tl_reg == '0)
        begin
            // leading whitespace
        end
        else if (!esc_reg && sp && !in_quote_reg)
        begin
            step.count    = 2'd1;
            step.r0       = r_end;
            in_quote_next = 1'b0;
            qm_next       = 1'b0;
            tl_next       = '0;
        end
        else if (!esc_reg && byte_in == qtr_pkg::CH_QUOTE)
        begin
            if (in_quote_reg)
            begin
                step.count    = 2'd1;
                step.r0       = r_end;
                in_quote_next = 1'b0;
                qm_next       = 1'b0;
                tl_next       = '0;
            end
            else
            begin
                qm_next       = qm_reg | (tl_reg != '0);
                in_quote_next = 1'b1;
            end
        end
        else if (!esc_reg && byte_in == qtr_pkg::CH_BSLASH)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            if (wide)
            begin
                if (fit2)
                begin
                    step.count = 2'd2;
                    step.r0    = r_k0;
                    step.r1    = r_k1;
                    tl_next    = tl_reg + qtr_pkg::len_t'(2);
                end
            end
            else if (fit1)
            begin
                step.count = 2'd1;
                step.r0    = r_k0;
                tl_next    = tl_reg + qtr_pkg::len_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg <= 1'b0;
            esc_reg      <= 1'b0;
            qm_reg       <= 1'b0;
            tl_reg       <= '0;
        end
        else if (advance)
        begin
            in_quote_reg <= in_quote_next;
            esc_reg      <= esc_next;
            qm_reg       <= qm_next;
            tl_reg       <= tl_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/qtr_obuf.sv
`default_nettype none
module qtr_obuf (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire qtr_pkg::step_t step,
    input  wire logic   out_stall,
    output logic        out_valid,
    output qtr_pkg::res_t head,
    output logic        free
);

    logic [1:0]    cnt_reg, cnt_next;
    qtr_pkg::res_t e0_reg, e0_next;
    qtr_pkg::res_t e1_reg, e1_next;
    logic          pop;

    always_comb
    begin
        out_valid = (cnt_reg != 2'd0);
        head      = e0_reg;
        pop       = out_valid && !out_stall;
        free      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
        cnt_next  = cnt_reg;
        e0_next   = e0_reg;
        e1_next   = e1_reg;
        if (load)
        begin
            cnt_next = step.count;
            e0_next  = step.r0;
            e1_next  = step.r1;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            e0_next  = e1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule
`default_nettype wire

>>> hdl/quoted_token_reader_core.sv
`default_nettype none
// Byte-stream tokenizer. Each input beat carries one raw byte (or an end-of-input
// mark) and produces zero, one or two result beats: token content bytes, then a
// token-end beat (kind 1 normal, kind 2 end of input) carrying the misplaced-quote
// flag; last marks the final result of each input byte. The byte is registered,
// decoded against the token state combinationally and written into a two-entry
// result buffer that drives the result outputs. A new byte is taken every
// cycle as long as each byte yields at most one result and out_stall stays low;
// a Latin-1 byte expanded into a two-byte UTF-8 pair takes two output beats, and
// that output buffer holds the input back. The user must write configuration
// via cfg_write/cfg_index/cfg_data with no bytes in flight; it is not enforced.
module quoted_token_reader_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        end_of_input,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [7:0]                       out_byte,
    output logic [1:0]                       kind,
    output logic                             bad_quote,
    output logic                             last,
    input  wire logic                        cfg_write,
    input  wire logic [qtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [qtr_pkg::CFG_W-1:0]   cfg_data
);

    logic                          a_valid_reg;
    logic [7:0]                    a_byte_reg;
    logic                          a_eoi_reg;
    logic                          latin1_reg;
    logic [qtr_pkg::CFG_LEN_W-1:0] max_len_reg;
    logic                          accept;
    logic                          advance;
    logic                          load;
    logic                          free;
    qtr_pkg::step_t                step;
    qtr_pkg::res_t                 head;

    assign advance  = a_valid_reg && (step.count == 2'd0 || free);
    assign load     = advance && (step.count != 2'd0);
    assign in_stall = a_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_byte_reg <= in_byte;
            a_eoi_reg  <= end_of_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latin1_reg  <= 1'b0;
            max_len_reg <= qtr_pkg::MAX_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qtr_pkg::CFG_LATIN1:  latin1_reg  <= cfg_data[0];
                qtr_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[qtr_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    qtr_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (a_byte_reg),
        .eoi     (a_eoi_reg),
        .latin1  (latin1_reg),
        .max_len (max_len_reg),
        .advance (advance),
        .step    (step)
    );

    qtr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .step      (step),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .free      (free)
    );

    assign out_byte  = head.data;
    assign kind      = head.kind;
    assign bad_quote = head.bad;
    assign last      = head.last;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg)
        else $error("input stalled with empty input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == qtr_pkg::KIND_DATA) |-> !bad_quote)
        else $error("bad_quote set on a content beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != qtr_pkg::KIND_DATA) |-> (last && out_byte == 8'h00))
        else $error("token end beat not last or carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == qtr_pkg::KIND_DATA || kind == qtr_pkg::KIND_END ||
                       kind == qtr_pkg::KIND_EOF))
        else $error("undefined result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

>>> verif/quoted_token_reader_core_tb.sv
`default_nettype none
module quoted_token_reader_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 225;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [7:0]                    in_byte      = 8'h00;
    logic                          end_of_input = 1'b0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [7:0]                    out_byte;
    logic [1:0]                    kind;
    logic                          bad_quote;
    logic                          last;
    logic                          cfg_write    = 1'b0;
    logic [qtr_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [qtr_pkg::CFG_W-1:0]     cfg_data     = '0;

    quoted_token_reader_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .kind         (kind),
        .bad_quote    (bad_quote),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial forever #6 clk = ~clk;

    // tokenizer state and register copies
    logic latin1_cfg  = 1'b0;
    int   max_len_cfg = int'(qtr_pkg::MAX_LEN_RESET);
    logic in_quote    = 1'b0;
    logic esc_pending = 1'b0;
    logic quote_seen  = 1'b0;
    int   tok_len     = 0;

    qtr_pkg::res_t token_stream_q[$];
    int   mismatches  = 0;
    int   items_sent  = 0;
    int   burst_left  = 0;
    int   quiet_cycles = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return c == qtr_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D) || c == qtr_pkg::CH_NBSP;
    endfunction

    function automatic logic [7:0] random_blank();
        int pick;
        pick = $urandom_range(0, 6);
        if (pick == 0)
            return qtr_pkg::CH_SPACE;
        if (pick == 6)
            return qtr_pkg::CH_NBSP;
        return 8'(8 + pick);
    endfunction

    function automatic logic [7:0] random_text();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == qtr_pkg::CH_QUOTE || c == qtr_pkg::CH_BSLASH);
        return c;
    endfunction

    task automatic add_beat(input logic [7:0] d, input logic [1:0] k, input logic b);
        qtr_pkg::res_t r;
        r.data = d;
        r.kind = k;
        r.bad  = b;
        r.last = 1'b0;
        token_stream_q.push_back(r);
    endtask

    task automatic clear_token_state();
        in_quote    = 1'b0;
        esc_pending = 1'b0;
        quote_seen  = 1'b0;
        tok_len     = 0;
    endtask

    task automatic keep_content(input logic [7:0] c);
        int lim;
        int len_cap;
        len_cap = (1 << qtr_pkg::LEN_BITS) - 1;
        lim = (max_len_cfg < len_cap) ? max_len_cfg : len_cap;
        if (latin1_cfg && c[7])
        begin
            if (tok_len + 2 <= lim)
            begin
                add_beat({6'b110000, c[7:6]}, qtr_pkg::KIND_DATA, 1'b0);
                add_beat({2'b10, c[5:0]}, qtr_pkg::KIND_DATA, 1'b0);
                tok_len += 2;
            end
        end
        else if (tok_len + 1 <= lim)
        begin
            add_beat(c, qtr_pkg::KIND_DATA, 1'b0);
            tok_len += 1;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
        int            size_before;
        qtr_pkg::res_t r;
        size_before = token_stream_q.size();
        if (eoi)
        begin
            add_beat(8'h00, qtr_pkg::KIND_EOF, quote_seen);
            clear_token_state();
        end
        else if (esc_pending)
        begin
            esc_pending = 1'b0;
            keep_content((c == qtr_pkg::CH_N) ? qtr_pkg::CH_NEWLINE : c);
        end
        else if (is_blank(c) && tok_len == 0)
        begin
            // leading blank dropped
        end
        else if (is_blank(c) && !in_quote)
        begin
            add_beat(8'h00, qtr_pkg::KIND_END, quote_seen);
            clear_token_state();
        end
        else if (c == qtr_pkg::CH_QUOTE)
        begin
            if (in_quote)
            begin
                add_beat(8'h00, qtr_pkg::KIND_END, quote_seen);
                clear_token_state();
            end
            else
            begin
                if (tok_len != 0)
                    quote_seen = 1'b1;
                in_quote = 1'b1;
            end
        end
        else if (c == qtr_pkg::CH_BSLASH)
        begin
            esc_pending = 1'b1;
        end
        else
        begin
            keep_content(c);
        end
        if (token_stream_q.size() > size_before)
        begin
            r = token_stream_q.pop_back();
            r.last = 1'b1;
            token_stream_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tokenize_byte(b, eoi);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_eof();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (token_stream_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic l1, input int ml);
        logic [31:0] l1_word;
        logic [31:0] ml_word;
        drain_results();
        l1_word   = ($urandom() << 1) | {31'd0, l1};
        ml_word   = ml;
        cfg_write <= 1'b1;
        cfg_index <= qtr_pkg::CFG_LATIN1;
        cfg_data  <= l1_word[qtr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= qtr_pkg::CFG_MAX_LEN;
        cfg_data  <= ml_word[qtr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        latin1_cfg  = l1;
        max_len_cfg = ml;
    endtask

    task automatic send_random_token();
        int   len;
        int   pick;
        logic quoted;
        repeat ($urandom_range(0, 2)) send_byte(random_blank(), 1'b0);
        quoted = 1'($urandom_range(0, 1));
        if (quoted)
        begin
            send_byte(qtr_pkg::CH_QUOTE, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_byte(random_blank(), 1'b0);
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 7);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                send_byte(qtr_pkg::CH_BSLASH, 1'b0);
                send_byte((pick < 4) ? qtr_pkg::CH_N : 8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 22)
            begin
                send_byte(8'($urandom_range(128, 255)), 1'b0);
            end
            else if (pick < 26)
            begin
                send_byte(qtr_pkg::CH_QUOTE, 1'b0);
            end
            else if (pick < 32 && quoted)
            begin
                send_byte(random_blank(), 1'b0);
            end
            else
            begin
                send_byte(random_text(), 1'b0);
            end
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            send_eof();
        else if (quoted)
            send_byte(qtr_pkg::CH_QUOTE, 1'b0);
        else
            send_byte(random_blank(), 1'b0);
    endtask

    // runs at reset values: whitespace, quoting, escapes, end of input
    task automatic test_token_rules();
        send_byte(qtr_pkg::CH_SPACE, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_text("a");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"b \"");
        send_text("\"");
        send_byte(qtr_pkg::CH_TAB, 1'b0);
        send_text("\\n\\\"\\\\\"");
        send_text("\"\"");
        send_text("\\ x");
        send_byte(qtr_pkg::CH_NBSP, 1'b0);
        send_eof();
        send_text("q");
        send_eof();
        send_text("\\");
        send_eof();
    endtask

    // utf-8 expansion against the length limit, including a zero limit
    task automatic test_latin1_limits();
        configure(1'b1, 3);
        send_text("a");
        send_byte(8'hE9, 1'b0);
        send_byte(8'hE9, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(qtr_pkg::CH_BSLASH, 1'b0);
        send_byte(qtr_pkg::CH_NBSP, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("z");
        send_byte(qtr_pkg::CH_CR, 1'b0);
        configure(1'b0, 0);
        send_text("ab ");
        send_eof();
        configure(1'b1, 1);
        send_byte(8'h80, 1'b0);
        send_text("yz ");
    endtask

    task automatic test_random_streams();
        int   phase_end;
        int   pick;
        logic l1;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                configure(1'b1, 4095);
            end
            else if (phase == 1)
            begin
                configure(1'b0, 1);
            end
            else
            begin
                l1   = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    configure(l1, $urandom_range(1, 8));
                else if (pick == 2)
                    configure(l1, $urandom_range(1, 4095));
                else
                    configure(l1, 4095);
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                end
                else
                begin
                    send_random_token();
                end
            end
        end
    endtask

    // result side stall pattern
    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_cycle = 0;

    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 64 == 0)
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (stall_cycle % 8) >= 5;
        endcase
    end

    always @(posedge clk)
    begin : check_beats
        qtr_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_stream_q.size() == 0)
            begin
                report_mismatch("beat with nothing expected", int'({out_byte, kind}), 0);
            end
            else
            begin
                want = token_stream_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", int'(out_byte), int'(want.data));
                if (kind !== want.kind)
                    report_mismatch("kind", int'(kind), int'(want.kind));
                if (bad_quote !== want.bad)
                    report_mismatch("bad_quote", int'(bad_quote), int'(want.bad));
                if (last !== want.last)
                    report_mismatch("last", int'(last), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL quoted_token_reader_core");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_token_rules();
        test_latin1_limits();
        test_random_streams();
        drain_results();
        if (mismatches == 0)
            $display("PASS quoted_token_reader_core");
        else
            $display("FAIL quoted_token_reader_core");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
hdl/qtr_pkg.sv
hdl/qtr_parse.sv
hdl/qtr_obuf.sv
hdl/quoted_token_reader_core.sv
verif/quoted_token_reader_core_tb.sv
